// File: design/mdd_pkg.sv
package mdd_pkg;

    // one window sample request
    typedef struct packed {
        logic [15:0] depth_sample;
        logic        last_sample;
        logic [11:0] pixel_u;
        logic [11:0] pixel_v;
    } in_item_t;

    // one deprojection result
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        median_mm;
        logic signed [23:0] left_mm;
        logic signed [23:0] up_mm;
    } out_item_t;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MM   = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam int QUO_W = 32;

    localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAT_MIN = 24'sh800000;

endpackage

// File: design/mdd_ram.sv
module mdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mdd_divider.sv
module mdd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mdd_pkg::div_req_t req,
    output mdd_pkg::div_rsp_t rsp
);

    logic [mdd_pkg::QUO_W-1:0] quo_reg;
    logic [15:0]               rem_reg;
    logic [15:0]               den_reg;
    logic [5:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [16:0]               shifted;
    logic                      fits;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[mdd_pkg::QUO_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                den_reg  <= req.divisor;
                cnt_reg  <= 6'(mdd_pkg::QUO_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 16'(shifted - {1'b0, den_reg}) : shifted[15:0];
                quo_reg <= {quo_reg[mdd_pkg::QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/median_depth_deprojection.sv
// channel   direction  handshake                  payload
// sample    in         start & !busy              in_item_t
// cfg       in         cfg_valid & cfg_ready      cfg_index, cfg_data
// result    out        done strobe, one cycle     out_item_t
//
// samples are accepted back to back while the block is idle
// after the last sample, the median search takes each kept sample as a candidate and counts
// its rank over the store's single read port; then each axis runs a multiply and a division
// on the shared radix-2 divider
// reset restores the register defaults and clears the sample count; the store needs no clearing pass
// results cannot be stalled: done is high for exactly one cycle per result
module median_depth_deprojection #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mdd_pkg::in_item_t                sample,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                      cfg_data,
    output logic                             done,
    output mdd_pkg::out_item_t               result
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_OUTER  = 9'b000000010,
        ST_LATCH  = 9'b000000100,
        ST_SCAN   = 9'b000001000,
        ST_TAIL   = 9'b000010000,
        ST_CHECK  = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_DSTART = 9'b010000000,
        ST_DIV    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [15:0] min_mm_reg, max_mm_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, j_reg, below_reg, nab_reg;
    logic          rv_reg;
    logic [15:0]   x_reg, median_reg;
    logic [11:0]   u_reg, v_reg;
    logic          axis_reg;
    logic signed [33:0] prod_reg;
    logic          neg_reg;
    logic signed [23:0] left_reg;
    logic          done_reg;
    mdd_pkg::out_item_t result_reg;

    logic          accept, ram_we;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;
    logic [CW-1:0] rank_k;
    logic          found, out_of_range;

    logic [11:0]        pix;
    logic [15:0]        center, focal;
    logic signed [16:0] diff;
    logic signed [33:0] prod_next;
    logic [33:0]        mag;
    logic signed [23:0] offset;

    mdd_pkg::div_req_t div_req;
    mdd_pkg::div_rsp_t div_rsp;

    assign accept    = start && !busy;
    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign ram_we    = accept && (sample.depth_sample != 16'd0)
                       && (count_reg < CW'(MAX_SAMPLES));
    assign count_next = ram_we ? count_reg + CW'(1) : count_reg;

    // sample store
    mdd_ram #(
        .WIDTH (16),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (sample.depth_sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // read address: candidate in outer pass, scan index otherwise
    assign raddr = (state_reg == ST_OUTER) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    // rank test for the upper median
    assign rank_k       = count_reg >> 1;
    assign found        = (below_reg <= rank_k) && (rank_k < nab_reg);
    assign out_of_range = (x_reg < min_mm_reg) || (x_reg > max_mm_reg);

    // axis operand selection and product
    assign pix       = axis_reg ? v_reg : u_reg;
    assign center    = axis_reg ? center_y_reg : center_x_reg;
    assign focal     = axis_reg ? focal_y_reg : focal_x_reg;
    assign diff      = $signed({1'b0, pix, 4'b0000}) - $signed({1'b0, center});
    assign prod_next = 34'(diff) * 34'($signed({1'b0, median_reg}));
    assign mag       = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);

    // divider request
    assign div_req.start    = state_reg == ST_DSTART;
    assign div_req.dividend = mag[31:0];
    assign div_req.divisor  = (focal == 16'd0) ? 16'd1 : focal;

    mdd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // negate quotient and saturate
    always_comb
    begin
        if (neg_reg)
        begin
            offset = (div_rsp.quotient > 32'd8388607) ? mdd_pkg::SAT_MAX
                     : $signed(div_rsp.quotient[23:0]);
        end
        else
        begin
            offset = (div_rsp.quotient > 32'd8388608) ? mdd_pkg::SAT_MIN
                     : $signed((~div_rsp.quotient[23:0]) + 24'd1);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && sample.last_sample && (count_next != '0))
                begin
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER:  state_next = ST_LATCH;
            ST_LATCH:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (j_reg == count_reg - CW'(1))
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:   state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!found)
                begin
                    state_next = ST_OUTER;
                end
                else if (out_of_range)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = axis_reg ? ST_IDLE : ST_MUL;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 16'd9600;
            focal_y_reg  <= 16'd9600;
            center_x_reg <= 16'd5120;
            center_y_reg <= 16'd3840;
            min_mm_reg   <= 16'd100;
            max_mm_reg   <= 16'd2000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mdd_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data;
                mdd_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                mdd_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                mdd_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                mdd_pkg::REG_MIN_MM:   min_mm_reg   <= cfg_data;
                mdd_pkg::REG_MAX_MM:   max_mm_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        if (sample.last_sample)
                        begin
                            u_reg    <= sample.pixel_u;
                            v_reg    <= sample.pixel_v;
                            i_reg    <= '0;
                            axis_reg <= 1'b0;
                            if (count_next == '0)
                            begin
                                done_reg             <= 1'b1;
                                result_reg.status    <= mdd_pkg::STATUS_EMPTY;
                                result_reg.median_mm <= '0;
                                result_reg.left_mm   <= '0;
                                result_reg.up_mm     <= '0;
                            end
                        end
                    end
                end
                ST_OUTER: ;
                ST_LATCH:
                begin
                    x_reg     <= rdata;
                    below_reg <= '0;
                    nab_reg   <= '0;
                    j_reg     <= '0;
                    rv_reg    <= 1'b0;
                end
                ST_SCAN, ST_TAIL:
                begin
                    j_reg  <= j_reg + CW'(1);
                    rv_reg <= 1'b1;
                    if (rv_reg)
                    begin
                        if (rdata < x_reg)
                        begin
                            below_reg <= below_reg + CW'(1);
                        end
                        if (rdata <= x_reg)
                        begin
                            nab_reg <= nab_reg + CW'(1);
                        end
                    end
                end
                ST_CHECK:
                begin
                    i_reg      <= i_reg + CW'(1);
                    median_reg <= x_reg;
                    if (found && out_of_range)
                    begin
                        count_reg            <= '0;
                        done_reg             <= 1'b1;
                        result_reg.status    <= mdd_pkg::STATUS_RANGE;
                        result_reg.median_mm <= x_reg;
                        result_reg.left_mm   <= '0;
                        result_reg.up_mm     <= '0;
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= prod_next;
                end
                ST_DSTART:
                begin
                    neg_reg <= prod_reg[33];
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        axis_reg <= 1'b1;
                        if (!axis_reg)
                        begin
                            left_reg <= offset;
                        end
                        else
                        begin
                            count_reg            <= '0;
                            done_reg             <= 1'b1;
                            result_reg.status    <= mdd_pkg::STATUS_OK;
                            result_reg.median_mm <= median_reg;
                            result_reg.left_mm   <= left_reg;
                            result_reg.up_mm     <= offset;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == mdd_pkg::STATUS_EMPTY |-> result.median_mm == 16'd0)
        else $error("empty window reports a median");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule

// File: tb/tb_median_depth_deprojection.sv
`timescale 1ns / 100ps

module tb_median_depth_deprojection;

    localparam int MAX_N      = 128;
    localparam int WATCH_MAX  = 200000;
    localparam int DRAIN_WAIT = 200;

    // register index outside the list
    localparam logic [mdd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    mdd_pkg::in_item_t   sample;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [mdd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic       done;
    mdd_pkg::out_item_t  result;

    median_depth_deprojection #(.MAX_SAMPLES(MAX_N)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .result(result)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of registers and window
    logic [15:0] m_focal_x, m_focal_y, m_center_x, m_center_y, m_min_mm, m_max_mm;
    logic [15:0] win_store[MAX_N];
    int          win_count;
    mdd_pkg::out_item_t pending_results[$];
    int          mismatches;
    int          results_seen;
    int          requests_sent;
    int          idle_pct;
    int          watchdog;
    int          status_hits[3];

    function automatic logic [15:0] upper_median(int n);
        logic [15:0] sorted_vals[$];
        for (int i = 0; i < n; i++)
            sorted_vals = {sorted_vals, win_store[i]};
        sorted_vals.sort();
        return sorted_vals[n / 2];
    endfunction

    function automatic logic signed [23:0] deproject(logic [11:0] pix, logic [15:0] ctr,
                                                     logic [15:0] depth, logic [15:0] focal);
        longint num, den, q;
        num = (longint'(pix) * 16 - longint'(ctr)) * longint'(depth);
        den = (focal == 16'd0) ? 1 : longint'(focal);
        q = -(num / den);
        if (q > 8388607)
            q = 8388607;
        if (q < -8388608)
            q = -8388608;
        return q[23:0];
    endfunction

    // window accumulation and result prediction
    task automatic predict_window(input mdd_pkg::in_item_t it);
        mdd_pkg::out_item_t r;
        logic [15:0] med;
        if (it.depth_sample != 16'd0 && win_count < MAX_N)
        begin
            win_store[win_count] = it.depth_sample;
            win_count++;
        end
        if (it.last_sample)
        begin
            r = '0;
            if (win_count == 0)
                r.status = mdd_pkg::STATUS_EMPTY;
            else
            begin
                med = upper_median(win_count);
                r.median_mm = med;
                if (med < m_min_mm || med > m_max_mm)
                    r.status = mdd_pkg::STATUS_RANGE;
                else
                begin
                    r.status  = mdd_pkg::STATUS_OK;
                    r.left_mm = deproject(it.pixel_u, m_center_x, med, m_focal_x);
                    r.up_mm   = deproject(it.pixel_v, m_center_y, med, m_focal_y);
                end
            end
            win_count = 0;
            pending_results = {pending_results, r};
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            mdd_pkg::out_item_t e;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                e = pending_results.pop_front();
                results_seen++;
                if (e.status <= mdd_pkg::STATUS_RANGE)
                    status_hits[e.status]++;
                if (result.status !== e.status || result.median_mm !== e.median_mm ||
                    result.left_mm !== e.left_mm || result.up_mm !== e.up_mm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, result);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request, register write or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCH_MAX)
        begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    // one register write, then cfg_valid drops before the task returns
    task automatic write_reg(input logic [mdd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            mdd_pkg::REG_FOCAL_X:  m_focal_x  = val;
            mdd_pkg::REG_FOCAL_Y:  m_focal_y  = val;
            mdd_pkg::REG_CENTER_X: m_center_x = val;
            mdd_pkg::REG_CENTER_Y: m_center_y = val;
            mdd_pkg::REG_MIN_MM:   m_min_mm   = val;
            mdd_pkg::REG_MAX_MM:   m_max_mm   = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // drop start, drain expected results then allow the block to settle
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // send one request, with random idle cycles before it
    task automatic send_request(input mdd_pkg::in_item_t it);
        while (idle_pct != 0 && int'($urandom_range(99, 0)) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_window(it);
        requests_sent++;
    endtask

    function automatic mdd_pkg::in_item_t mk(logic [15:0] d, logic l, logic [11:0] u,
                                             logic [11:0] v);
        mdd_pkg::in_item_t it;
        it.depth_sample = d;
        it.last_sample  = l;
        it.pixel_u      = u;
        it.pixel_v      = v;
        return it;
    endfunction

    // one random window; mostly sensible depths, some noise
    task automatic random_window(input int max_len);
        int          len;
        int          mode;
        logic [15:0] d;
        logic [15:0] base;
        len  = ($urandom_range(9, 0) == 0) ? int'($urandom_range(max_len, 1))
                                          : int'($urandom_range(12, 1));
        mode = int'($urandom_range(9, 0));
        base = 16'($urandom_range(int'(m_max_mm) + 200, 0));
        for (int i = 0; i < len; i++)
        begin
            if (mode == 0)
                d = 16'($urandom);
            else if ($urandom_range(5, 0) == 0)
                d = 16'd0;
            else
                d = 16'(int'(base) + int'($urandom_range(60, 0)) - 30);
            send_request(mk(d, i == len - 1, 12'($urandom), 12'($urandom)));
        end
    endtask

    typedef struct {
        mdd_pkg::in_item_t  it;
        logic               check_lit;
        mdd_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic dir_row_t row(mdd_pkg::in_item_t it, logic lit, mdd_pkg::out_item_t w);
        dir_row_t r;
        r.it = it;
        r.check_lit = lit;
        r.want = w;
        return r;
    endfunction

    initial
    begin
        mdd_pkg::out_item_t none;
        mdd_pkg::out_item_t lit;
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = mdd_pkg::REG_FOCAL_X;
        cfg_data = '0;
        requests_sent = 0;
        idle_pct = 0;
        win_count = 0;
        m_focal_x = 16'd9600;
        m_focal_y = 16'd9600;
        m_center_x = 16'd5120;
        m_center_y = 16'd3840;
        m_min_mm = 16'd100;
        m_max_mm = 16'd2000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: literal rows after reset, predictor for the rest
        lit = '0;
        lit.status = mdd_pkg::STATUS_EMPTY;
        dir_rows = {dir_rows, row(mk(16'd0, 1'b1, 12'd0, 12'd0), 1'b1, lit)};
        lit.status = mdd_pkg::STATUS_OK;
        lit.median_mm = 16'd1000;
        dir_rows = {dir_rows, row(mk(16'd1000, 1'b1, 12'd320, 12'd240), 1'b1, lit)};
        lit.status = mdd_pkg::STATUS_RANGE;
        lit.median_mm = 16'hFFFF;
        dir_rows = {dir_rows, row(mk(16'hFFFF, 1'b1, 12'hFFF, 12'hFFF), 1'b1, lit)};
        lit.median_mm = 16'd99;
        dir_rows = {dir_rows, row(mk(16'd99, 1'b1, 12'd0, 12'd0), 1'b1, lit)};
        dir_rows = {dir_rows, row(mk(16'd300, 1'b0, 12'd0, 12'd0), 1'b0, none)};
        dir_rows = {dir_rows, row(mk(16'd0, 1'b0, 12'd0, 12'd0), 1'b0, none)};
        dir_rows = {dir_rows, row(mk(16'd100, 1'b0, 12'd0, 12'd0), 1'b0, none)};
        dir_rows = {dir_rows, row(mk(16'd2000, 1'b1, 12'hFFF, 12'd0), 1'b0, none)};
        dir_rows = {dir_rows, row(mk(16'd1500, 1'b0, 12'd7, 12'd9), 1'b0, none)};
        dir_rows = {dir_rows, row(mk(16'd100, 1'b1, 12'd0, 12'hFFF), 1'b0, none)};
        dir_rows = {dir_rows, row(mk(16'd2000, 1'b1, 12'hAAA, 12'h555), 1'b0, none)};
        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].it);
            // literal rows: the typed-in result replaces the prediction
            if (dir_rows[i].check_lit)
                pending_results[pending_results.size() - 1] = dir_rows[i].want;
        end
        wait_quiet();

        // store full: more kept samples than the store holds
        for (int i = 0; i < MAX_N + 10; i++)
            send_request(mk(16'd50 + i[15:0] * 16'd11, i == MAX_N + 9, 12'd100, 12'd200));
        wait_quiet();

        // extreme settings: zero focal, swapped range, wide range
        write_reg(mdd_pkg::REG_FOCAL_X, 16'd0);
        write_reg(mdd_pkg::REG_FOCAL_Y, 16'd0);
        write_reg(mdd_pkg::REG_CENTER_X, 16'hFFFF);
        write_reg(mdd_pkg::REG_CENTER_Y, 16'd0);
        write_reg(mdd_pkg::REG_MIN_MM, 16'd0);
        write_reg(mdd_pkg::REG_MAX_MM, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h1234);
        send_request(mk(16'hFFFF, 1'b1, 12'hFFF, 12'hFFF));
        send_request(mk(16'd1, 1'b1, 12'd0, 12'hFFF));
        send_request(mk(16'd1, 1'b1, 12'hFFF, 12'd0));
        wait_quiet();
        write_reg(mdd_pkg::REG_MIN_MM, 16'd500);
        write_reg(mdd_pkg::REG_MAX_MM, 16'd400);
        send_request(mk(16'd450, 1'b1, 12'd3, 12'd3));
        wait_quiet();

        // random phases through several register settings and idle rates
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(mdd_pkg::REG_FOCAL_X,
                      (ph == 1) ? 16'hFFFF : 16'($urandom_range(65535, 16)));
            write_reg(mdd_pkg::REG_FOCAL_Y,
                      (ph == 1) ? 16'd16 : 16'($urandom_range(65535, 16)));
            write_reg(mdd_pkg::REG_CENTER_X, 16'($urandom));
            write_reg(mdd_pkg::REG_CENTER_Y, 16'($urandom));
            write_reg(mdd_pkg::REG_MIN_MM, 16'($urandom_range(800, 0)));
            write_reg(mdd_pkg::REG_MAX_MM,
                      (ph == 2) ? 16'hFFFF : 16'($urandom_range(65535, 900)));
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 83;
                2: idle_pct = 24;
                default: idle_pct = 0;
            endcase
            while (requests_sent < 225 * (ph + 1))
                random_window(40);
            wait_quiet();
        end

        $display("sent %0d sample requests, checked %0d results", requests_sent, results_seen);
        $display("status ok %0d, empty %0d, out of range %0d",
                 status_hits[0], status_hits[1], status_hits[2]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
